FILE: hw/rtl/dual_stack_shared_memory_assert.svh
// assertion macros used by the checker file
`ifndef DUAL_STACK_SHARED_MEMORY_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define DSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsm assertion failed");

// next-cycle implication, disabled while reset is high
`define DSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsm assertion failed");

// delayed implication, disabled while reset is high
`define DSM_ASSERT_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("dsm assertion failed");

`endif

FILE: hw/rtl/dsm_pkg.sv
`default_nettype none

package dsm_pkg;

   localparam int unsigned DATA_WIDTH   = 32;
   localparam int unsigned COUNT_WIDTH  = 9;
   localparam int unsigned FUNC_WIDTH   = 3;
   localparam int unsigned STATUS_WIDTH = 2;

   // capacity after reset
   localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = 9'd256;

   // operation codes
   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH1 = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH2 = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP1  = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP2  = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TOP1  = 3'd4;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TOP2  = 3'd5;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic                    push_low;
      logic                    push_high;
      logic                    read_low;
      logic                    read_high;
      logic                    pop_low;
      logic                    pop_high;
      logic                    rsp_load;
      logic                    rsp_read;
      logic [STATUS_WIDTH-1:0] rsp_status;
   } dsm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty_low;
      logic empty_high;
   } dsm_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dsm_if.sv
`default_nettype none

// request channel
interface dsm_req_if;
   import dsm_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [FUNC_WIDTH-1:0]        func;
   logic signed [DATA_WIDTH-1:0] push_value;
   modport source (output valid, input ready, output func, output push_value);
   modport sink   (input valid, output ready, input func, input push_value);
endinterface

// response channel
interface dsm_rsp_if;
   import dsm_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] read_value;
   logic [STATUS_WIDTH-1:0]      status;
   logic [COUNT_WIDTH-1:0]       count_low;
   logic [COUNT_WIDTH-1:0]       count_high;
   modport source (output valid, input ready, output read_value, output status,
                   output count_low, output count_high);
   modport sink   (input valid, output ready, input read_value, input status,
                   input count_low, input count_high);
endinterface

// capacity register write channel
interface dsm_csr_if;
   import dsm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] capacity;
   modport source (output valid, input ready, output capacity);
   modport sink   (input valid, output ready, input capacity);
endinterface

`default_nettype wire

FILE: hw/rtl/dsm_ctrl.sv
`default_nettype none

module dsm_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dsm_pkg::FUNC_WIDTH-1:0] req_func,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  dsm_pkg::dsm_stat_type          stat,
   output dsm_pkg::dsm_cmd_type           cmd
);
   import dsm_pkg::*;

   typedef enum logic {ST_IDLE, ST_BUSY} state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] pend_status_ff, pend_status_in;
   logic                    pend_read_ff, pend_read_in;
   logic                    accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // decode the accepted transaction against the stack status
   always_comb begin
      cmd            = '0;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      cmd.rsp_load   = (state_ff == ST_BUSY) && (!rsp_valid_ff || rsp_ready);
      cmd.rsp_status = pend_status_ff;
      cmd.rsp_read   = pend_read_ff;
      if (accept) begin
         pend_status_in = STATUS_OK;
         pend_read_in   = 1'b0;
         case (req_func)
            FUNC_PUSH1: begin
               if (stat.full) pend_status_in = STATUS_OVERFLOW;
               else           cmd.push_low   = 1'b1;
            end
            FUNC_PUSH2: begin
               if (stat.full) pend_status_in = STATUS_OVERFLOW;
               else           cmd.push_high  = 1'b1;
            end
            FUNC_POP1, FUNC_TOP1: begin
               if (stat.empty_low) begin
                  pend_status_in = STATUS_UNDERFLOW;
               end else begin
                  cmd.read_low = 1'b1;
                  cmd.pop_low  = (req_func == FUNC_POP1);
                  pend_read_in = 1'b1;
               end
            end
            FUNC_POP2, FUNC_TOP2: begin
               if (stat.empty_high) begin
                  pend_status_in = STATUS_UNDERFLOW;
               end else begin
                  cmd.read_high = 1'b1;
                  cmd.pop_high  = (req_func == FUNC_POP2);
                  pend_read_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept)       state_in = ST_BUSY;
         ST_BUSY: if (cmd.rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dsm_datapath.sv
`default_nettype none

module dsm_datapath #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dsm_pkg::dsm_cmd_type                  cmd,
   output dsm_pkg::dsm_stat_type                 stat,
   input  logic signed [dsm_pkg::DATA_WIDTH-1:0] push_value,
   input  logic                                  csr_we,
   input  logic [dsm_pkg::COUNT_WIDTH-1:0]       csr_capacity,
   output logic signed [dsm_pkg::DATA_WIDTH-1:0] read_value,
   output logic [dsm_pkg::STATUS_WIDTH-1:0]      status,
   output logic [dsm_pkg::COUNT_WIDTH-1:0]       count_low,
   output logic [dsm_pkg::COUNT_WIDTH-1:0]       count_high
);
   import dsm_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;
   localparam logic [COUNT_WIDTH-1:0] CAP_LIMIT =
      COUNT_WIDTH'((DEPTH < COUNT_MAX) ? DEPTH : COUNT_MAX);

   logic [COUNT_WIDTH-1:0]       capacity_ff, capacity_in;
   logic [COUNT_WIDTH-1:0]       depth_low_ff, depth_low_in;
   logic [COUNT_WIDTH-1:0]       depth_high_ff, depth_high_in;
   logic [COUNT_WIDTH-1:0]       cap_eff;
   logic [COUNT_WIDTH:0]         used;
   logic [COUNT_WIDTH-1:0]       waddr9, raddr9;
   logic [AW-1:0]                waddr, raddr;
   logic                         wen, ren;
   logic [DATA_WIDTH-1:0]        store_mem [DEPTH];
   logic [DATA_WIDTH-1:0]        rdata_ff;
   logic signed [DATA_WIDTH-1:0] read_value_ff;
   logic [STATUS_WIDTH-1:0]      status_ff;
   logic [COUNT_WIDTH-1:0]       count_low_ff, count_high_ff;

   // capacity saturates at the memory depth
   assign cap_eff = (capacity_ff > CAP_LIMIT) ? CAP_LIMIT : capacity_ff;
   assign used    = {1'b0, depth_low_ff} + {1'b0, depth_high_ff};

   assign stat.full       = (used >= {1'b0, cap_eff});
   assign stat.empty_low  = (depth_low_ff == '0);
   assign stat.empty_high = (depth_high_ff == '0);

   // memory addresses: stack one from the bottom, stack two from the top
   assign wen    = cmd.push_low || cmd.push_high;
   assign ren    = cmd.read_low || cmd.read_high;
   assign waddr9 = cmd.push_low ? depth_low_ff : (cap_eff - depth_high_ff - 1'b1);
   assign raddr9 = cmd.read_low ? (depth_low_ff - 1'b1) : (cap_eff - depth_high_ff);
   assign waddr  = AW'(waddr9);
   assign raddr  = AW'(raddr9);

   // stack sizes and capacity register
   always_comb begin
      capacity_in   = capacity_ff;
      depth_low_in  = depth_low_ff;
      depth_high_in = depth_high_ff;
      if (csr_we) begin
         capacity_in   = csr_capacity;
         depth_low_in  = '0;
         depth_high_in = '0;
      end else begin
         if (cmd.push_low)  depth_low_in  = depth_low_ff + 1'b1;
         if (cmd.pop_low)   depth_low_in  = depth_low_ff - 1'b1;
         if (cmd.push_high) depth_high_in = depth_high_ff + 1'b1;
         if (cmd.pop_high)  depth_high_in = depth_high_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         depth_low_ff  <= '0;
         depth_high_ff <= '0;
      end else begin
         capacity_ff   <= capacity_in;
         depth_low_ff  <= depth_low_in;
         depth_high_ff <= depth_high_in;
      end
   end

   // shared stack memory, registered read
   always_ff @(posedge clock) begin
      if (wen) store_mem[waddr] <= push_value;
      if (ren) rdata_ff <= store_mem[raddr];
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         read_value_ff <= cmd.rsp_read ? rdata_ff : '0;
         status_ff     <= cmd.rsp_status;
         count_low_ff  <= depth_low_ff;
         count_high_ff <= depth_high_ff;
      end
   end

   assign read_value = read_value_ff;
   assign status     = status_ff;
   assign count_low  = count_low_ff;
   assign count_high = count_high_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dual_stack_shared_memory.sv
// an accepted request passes the memory read register and then the response register;
//   the response register waits while an earlier response is not yet taken on rsp
// a new request is taken only after the last one has reached the response register,
//   and it is taken while that finished response still waits on rsp
// reset: synchronous, clears both stack sizes, sets capacity to 256 and
//   empties the response; memory contents are not cleared
`default_nettype none

module dual_stack_shared_memory #(
   parameter int unsigned DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   dsm_req_if.sink    req_if,
   dsm_rsp_if.source  rsp_if,
   dsm_csr_if.sink    csr_if
);
   import dsm_pkg::*;

   dsm_cmd_type  cmd;
   dsm_stat_type stat;
   logic         csr_we;

   // capacity writes are always taken
   assign csr_if.ready = 1'b1;
   assign csr_we       = csr_if.valid;

   // control state machine
   dsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_func  (req_if.func),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stack memory, pointers and response register
   dsm_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .push_value   (req_if.push_value),
      .csr_we       (csr_we),
      .csr_capacity (csr_if.capacity),
      .read_value   (rsp_if.read_value),
      .status       (rsp_if.status),
      .count_low    (rsp_if.count_low),
      .count_high   (rsp_if.count_high)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/dsm_checker.sv
`default_nettype none

`include "dual_stack_shared_memory_assert.svh"

module dsm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [dsm_pkg::DATA_WIDTH-1:0] rsp_read_value,
   input  logic [dsm_pkg::STATUS_WIDTH-1:0]      rsp_status
);
   import dsm_pkg::*;

   // a waiting response stays offered
   `DSM_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one transaction in flight: no request taken right after another
   `DSM_ASSERT_NEXT(req_gap_a, clock, reset, req_valid && req_ready, !req_ready)

   // every accepted request is followed by a response being offered
   `DSM_ASSERT_TWO(rsp_due_a, clock, reset, req_valid && req_ready, rsp_valid)

   // errors never carry a read value
   `DSM_ASSERT_NOW(err_zero_a, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
                   rsp_read_value == '0)

endmodule

bind dual_stack_shared_memory dsm_checker u_dsm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_read_value (rsp_if.read_value),
   .rsp_status     (rsp_if.status)
);

`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dsm_pkg::*;

   localparam int unsigned STORE_DEPTH = 256;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned DRILL_ROWS  = 27;

   // operation codes the block takes but ignores
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE6 = 3'd6;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE7 = 3'd7;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] read_value;
      logic [STATUS_WIDTH-1:0]      status;
      logic [COUNT_WIDTH-1:0]       count_low;
      logic [COUNT_WIDTH-1:0]       count_high;
   } stack_result_type;

   // one directed step: either a capacity write or an operation
   typedef struct {
      bit                      is_cap;
      logic [COUNT_WIDTH-1:0]  cap;
      logic [FUNC_WIDTH-1:0]   func;
      logic [DATA_WIDTH-1:0]   value;
      bit                      typed;
      logic [DATA_WIDTH-1:0]   want_read;
      logic [STATUS_WIDTH-1:0] want_status;
      logic [COUNT_WIDTH-1:0]  want_low;
      logic [COUNT_WIDTH-1:0]  want_high;
   } drill_row_type;

   logic clock;
   logic reset;

   dsm_req_if req_bus ();
   dsm_rsp_if rsp_bus ();
   dsm_csr_if csr_bus ();

   dual_stack_shared_memory #(.DEPTH(STORE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow copy of the two stacks
   logic [DATA_WIDTH-1:0]  mem_image [STORE_DEPTH];
   int unsigned            size_one;
   int unsigned            size_two;
   logic [COUNT_WIDTH-1:0] cap_reg;

   stack_result_type stack_results_due [$];

   int error_count;
   int op_count;
   int overflow_count;
   int underflow_count;
   int cap_writes;
   int burst_left;

   drill_row_type drill_plan [DRILL_ROWS] = '{
      // empty stacks after reset
      '{0, 9'd0, FUNC_POP1, 32'h0, 1, 32'h0, STATUS_UNDERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_POP2, 32'h0, 1, 32'h0, STATUS_UNDERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_TOP1, 32'h0, 1, 32'h0, STATUS_UNDERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_TOP2, 32'h0, 1, 32'h0, STATUS_UNDERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_SPARE6, 32'h0, 1, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_SPARE7, 32'hFFFF_FFFF, 1, 32'h0, STATUS_OK, 9'd0, 9'd0},
      // value extremes on both stacks
      '{0, 9'd0, FUNC_PUSH1, 32'h7FFF_FFFF, 1, 32'h0, STATUS_OK, 9'd1, 9'd0},
      '{0, 9'd0, FUNC_PUSH2, 32'h8000_0000, 1, 32'h0, STATUS_OK, 9'd1, 9'd1},
      '{0, 9'd0, FUNC_PUSH1, 32'hFFFF_FFFF, 1, 32'h0, STATUS_OK, 9'd2, 9'd1},
      '{0, 9'd0, FUNC_TOP1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_TOP2, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_POP1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_POP1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_POP2, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      // zero capacity: no room at all
      '{1, 9'd0, FUNC_PUSH1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_PUSH1, 32'h1234_5678, 1, 32'h0, STATUS_OVERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_PUSH2, 32'h1234_5678, 1, 32'h0, STATUS_OVERFLOW, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_TOP2, 32'h0, 1, 32'h0, STATUS_UNDERFLOW, 9'd0, 9'd0},
      // single entry shared by both stacks
      '{1, 9'd1, FUNC_PUSH1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_PUSH2, 32'h5555_5555, 1, 32'h0, STATUS_OK, 9'd0, 9'd1},
      '{0, 9'd0, FUNC_PUSH1, 32'h0000_0001, 1, 32'h0, STATUS_OVERFLOW, 9'd0, 9'd1},
      '{0, 9'd0, FUNC_POP2, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      // capacity above the store size saturates
      '{1, 9'd511, FUNC_PUSH1, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_PUSH2, 32'hAAAA_AAAA, 1, 32'h0, STATUS_OK, 9'd0, 9'd1},
      '{0, 9'd0, FUNC_TOP2, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0},
      '{0, 9'd0, FUNC_PUSH1, 32'h0000_0000, 1, 32'h0, STATUS_OK, 9'd1, 9'd1},
      '{0, 9'd0, FUNC_POP2, 32'h0, 0, 32'h0, STATUS_OK, 9'd0, 9'd0}
   };

   int unsigned phase_cap [PHASES] = '{511, 0, 1, 2, 256, 0, 0, 255};
   int unsigned phase_len [PHASES] = '{360, 25, 40, 40, 360, 150, 150, 125};

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // apply one operation to the shadow stacks and return its result
   function automatic stack_result_type apply_stack_op(input logic [FUNC_WIDTH-1:0] f,
                                                       input logic [DATA_WIDTH-1:0] v);
      stack_result_type r;
      int unsigned      room;
      bit               full;
      room = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg;
      full = (size_one + size_two) >= room;
      r.read_value = '0;
      r.status     = STATUS_OK;
      case (f)
         FUNC_PUSH1: begin
            if (full) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               mem_image[size_one % STORE_DEPTH] = v;
               size_one++;
            end
         end
         FUNC_PUSH2: begin
            if (full) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               size_two++;
               mem_image[(room - size_two) % STORE_DEPTH] = v;
            end
         end
         FUNC_POP1, FUNC_TOP1: begin
            if (size_one == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = mem_image[(size_one - 1) % STORE_DEPTH];
               if (f == FUNC_POP1) size_one--;
            end
         end
         FUNC_POP2, FUNC_TOP2: begin
            if (size_two == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = mem_image[(room - size_two) % STORE_DEPTH];
               if (f == FUNC_POP2) size_two--;
            end
         end
         default: ;
      endcase
      r.count_low  = size_one[COUNT_WIDTH-1:0];
      r.count_high = size_two[COUNT_WIDTH-1:0];
      return r;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // push-heavy while filling, pop-heavy while draining
   function automatic logic [FUNC_WIDTH-1:0] pick_func(input bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (filling) begin
         if (r < 44) return FUNC_PUSH1;
         if (r < 88) return FUNC_PUSH2;
         if (r < 91) return FUNC_POP1;
         if (r < 94) return FUNC_POP2;
         if (r < 96) return FUNC_TOP1;
         if (r < 98) return FUNC_TOP2;
      end else begin
         if (r < 8)  return FUNC_PUSH1;
         if (r < 16) return FUNC_PUSH2;
         if (r < 50) return FUNC_POP1;
         if (r < 84) return FUNC_POP2;
         if (r < 92) return FUNC_TOP1;
         if (r < 98) return FUNC_TOP2;
      end
      return ($urandom_range(0, 1) != 0) ? FUNC_SPARE7 : FUNC_SPARE6;
   endfunction

   // one request transaction, predicted when it is accepted
   task automatic send_op(input logic [FUNC_WIDTH-1:0] f, input logic [DATA_WIDTH-1:0] v,
                          input bit typed, input stack_result_type want);
      stack_result_type due;
      int               gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= f;
      req_bus.push_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      due = apply_stack_op(f, v);
      if (typed) due = want;
      stack_results_due.push_back(due);
      op_count++;
      if (due.status == STATUS_OVERFLOW) overflow_count++;
      if (due.status == STATUS_UNDERFLOW) underflow_count++;
   endtask

   // capacity write, only once every result is back
   task automatic write_capacity(input logic [COUNT_WIDTH-1:0] value);
      req_bus.valid <= 1'b0;
      while (stack_results_due.size() != 0) @(posedge clock);
      csr_bus.valid    <= 1'b1;
      csr_bus.capacity <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      cap_reg  = value;
      size_one = 0;
      size_two = 0;
      cap_writes++;
   endtask

   // response ready with random stalls
   initial begin
      int  hold_left;
      int  r;
      bit  level;
      hold_left   = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            level = ($urandom_range(0, 99) < 65);
            r     = $urandom_range(0, 99);
            if (level) begin
               hold_left = (r < 90) ? $urandom_range(1, 12) : $urandom_range(50, 150);
            end else if (r < 75) begin
               hold_left = $urandom_range(1, 2);
            end else if (r < 95) begin
               hold_left = $urandom_range(3, 8);
            end else begin
               hold_left = $urandom_range(20, 60);
            end
            hold_left--;
            rsp_bus.ready <= level;
         end
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      stack_result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (stack_results_due.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            due = stack_results_due.pop_front();
            if (rsp_bus.read_value !== due.read_value) begin
               $error("read_value: expected %h, got %h", due.read_value, rsp_bus.read_value);
               error_count++;
            end
            if (rsp_bus.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.count_low !== due.count_low) begin
               $error("count_low: expected %0d, got %0d", due.count_low, rsp_bus.count_low);
               error_count++;
            end
            if (rsp_bus.count_high !== due.count_high) begin
               $error("count_high: expected %0d, got %0d", due.count_high,
                      rsp_bus.count_high);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      stack_result_type want;
      int unsigned      done;
      int unsigned      room;
      bit               filling;
      logic [FUNC_WIDTH-1:0] f;

      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_PUSH1;
      req_bus.push_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.capacity   = CAPACITY_RESET;
      reset              = 1'b1;
      error_count        = 0;
      op_count           = 0;
      overflow_count     = 0;
      underflow_count    = 0;
      cap_writes         = 0;
      burst_left         = 0;
      size_one           = 0;
      size_two           = 0;
      cap_reg            = CAPACITY_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DRILL_ROWS; i++) begin
         if (drill_plan[i].is_cap) begin
            write_capacity(drill_plan[i].cap);
         end else begin
            want.read_value = drill_plan[i].want_read;
            want.status     = drill_plan[i].want_status;
            want.count_low  = drill_plan[i].want_low;
            want.count_high = drill_plan[i].want_high;
            send_op(drill_plan[i].func, drill_plan[i].value, drill_plan[i].typed, want);
         end
      end

      // random phases: fill until the stacks meet, then drain until both are empty
      phase_cap[5] = $urandom_range(3, 64);
      phase_cap[6] = $urandom_range(0, 511);
      want = '0;
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_cap[p][COUNT_WIDTH-1:0]);
         filling = 1'b1;
         done    = 0;
         while (done < phase_len[p]) begin
            if ($urandom_range(0, 79) == 0) burst_left = 25;
            f = pick_func(filling);
            send_op(f, pick_value(), 1'b0, want);
            if (f <= FUNC_TOP2) done++;
            room = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg;
            if (filling && (size_one + size_two) >= room) filling = 1'b0;
            else if (!filling && size_one == 0 && size_two == 0) filling = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      while (stack_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("ran %0d operations over %0d capacity settings", op_count, cap_writes);
      $display("saw %0d overflows and %0d underflows", overflow_count, underflow_count);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
